// ----- src/hse_pkg.sv -----
// ============================================================================
// hse_pkg
// Shared types and constants for the heap sort engine: widths, default
// capacity, controller states and the command/status bundles.
// ============================================================================
package hse_pkg;

    localparam int HSE_DW       = 32;
    localparam int HSE_CAPACITY = 64;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BLD_INIT,
        ST_BLD_CHK,
        ST_SFT_RDP,
        ST_SFT_GETV,
        ST_SFT_RDL,
        ST_SFT_RDR,
        ST_SFT_CMP,
        ST_SFT_DEC,
        ST_EXT_CHK,
        ST_EXT_RD0,
        ST_EXT_RDE,
        ST_EXT_WR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } hse_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;            // input transfer this cycle
        logic bld_init;        // latch heap size and first build index
        logic bld_dec;         // step build index down, set sift position
        logic rd_pos;          // read entry at sift position
        logic cap_val;         // capture the value being sifted
        logic rd_lc;           // read left child
        logic wr_val;          // write sifted value at its final position
        logic cap_lc_rd_rc;    // capture left child, read right child
        logic cap_rc;          // capture right child, compare left child
        logic sft_move;        // move larger child up, descend
        logic rd_root;         // read heap root
        logic cap_root_rd_end; // capture root, read last heap entry
        logic ext_swap;        // root to heap end, shrink heap
        logic emit_init;       // reset emission index
        logic emit_rd;         // read entry to emit
        logic emit_ld;         // load output register
        logic run_done;        // clear count and drop flag
    } hse_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bi_zero;
        logic hsize_gt1;
        logic lc_in;
        logic big_none;
        logic out_busy;
        logic emit_last;
    } hse_sts_t;

endpackage

// ----- src/hse_datapath.sv -----
// ============================================================================
// hse_datapath
// Element memory, heap index registers, sift compare logic and the output
// register of the heap sort engine.
// ============================================================================
module hse_datapath
    import hse_pkg::*;
#(
    parameter int CAPACITY = HSE_CAPACITY
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  hse_cmd_t          cmd,
    output hse_sts_t          sts,
    input  logic [HSE_DW-1:0] in_value,
    output logic [HSE_DW-1:0] out_value,
    output logic              out_last,
    output logic              out_ovf,
    output logic              out_valid,
    input  logic              out_ready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    logic signed [HSE_DW-1:0] mem [CAPACITY];

    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [CW-1:0] bi_reg;
    logic [CW-1:0] hsize_reg;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] k_reg;
    logic signed [HSE_DW-1:0] val_reg;
    logic signed [HSE_DW-1:0] tmp_reg;
    logic signed [HSE_DW-1:0] rc_reg;
    logic          lc_gt_reg;
    logic signed [HSE_DW-1:0] rd_data_reg;
    logic [HSE_DW-1:0] out_value_reg;
    logic          out_last_reg;
    logic          out_ovf_reg;
    logic          out_valid_reg;

    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic signed [HSE_DW-1:0] wr_data;

    logic [IW-1:0] lc_idx;
    logic [IW-1:0] rc_idx;
    logic [IW-1:0] hsize_ext;
    logic          lc_in;
    logic          rc_in;
    logic          rc_gt;
    logic [IW-1:0] big_idx;
    logic signed [HSE_DW-1:0] big_val;
    logic [AW-1:0] end_addr;
    logic          full;
    logic          emit_last;

    assign full      = (count_reg == CW'(CAPACITY));
    assign lc_idx    = {1'b0, pos_reg, 1'b1};
    assign rc_idx    = {1'b0, pos_reg, 1'b0} + IW'(2);
    assign hsize_ext = IW'(hsize_reg);
    assign lc_in     = (lc_idx < hsize_ext);
    assign rc_in     = (rc_idx < hsize_ext);
    // The right child wins only if it beats the better of parent and left child.
    assign rc_gt     = rc_in && (rc_reg > (lc_gt_reg ? tmp_reg : val_reg));
    assign big_idx   = rc_gt ? rc_idx : lc_idx;
    assign big_val   = rc_gt ? rc_reg : tmp_reg;
    assign end_addr  = AW'(hsize_reg - CW'(1));
    assign emit_last = (CW'(k_reg) == (count_reg - CW'(1)));

    always_comb begin
        rd_addr = '0;
        if (cmd.rd_pos) begin
            rd_addr = pos_reg;
        end else if (cmd.rd_lc) begin
            rd_addr = lc_idx[AW-1:0];
        end else if (cmd.cap_lc_rd_rc) begin
            rd_addr = rc_idx[AW-1:0];
        end else if (cmd.rd_root) begin
            rd_addr = '0;
        end else if (cmd.cap_root_rd_end) begin
            rd_addr = end_addr;
        end else if (cmd.emit_rd) begin
            rd_addr = k_reg;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = val_reg;
        if (cmd.load && !full) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[AW-1:0];
            wr_data = in_value;
        end else if (cmd.wr_val) begin
            wr_en   = 1'b1;
            wr_addr = pos_reg;
            wr_data = val_reg;
        end else if (cmd.sft_move) begin
            wr_en   = 1'b1;
            wr_addr = pos_reg;
            wr_data = big_val;
        end else if (cmd.ext_swap) begin
            wr_en   = 1'b1;
            wr_addr = end_addr;
            wr_data = tmp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.load) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.run_done) begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            if (cmd.emit_ld) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.bld_init) begin
            bi_reg    <= count_reg >> 1;
            hsize_reg <= count_reg;
        end
        if (cmd.bld_dec) begin
            bi_reg  <= bi_reg - CW'(1);
            pos_reg <= AW'(bi_reg - CW'(1));
        end
        if (cmd.cap_val) begin
            val_reg <= rd_data_reg;
        end
        if (cmd.cap_lc_rd_rc || cmd.cap_root_rd_end) begin
            tmp_reg <= rd_data_reg;
        end
        if (cmd.cap_rc) begin
            rc_reg    <= rd_data_reg;
            lc_gt_reg <= lc_in && (tmp_reg > val_reg);
        end
        if (cmd.sft_move) begin
            pos_reg <= big_idx[AW-1:0];
        end
        if (cmd.ext_swap) begin
            val_reg   <= rd_data_reg;
            hsize_reg <= hsize_reg - CW'(1);
            pos_reg   <= '0;
        end
        if (cmd.emit_init) begin
            k_reg <= '0;
        end
        if (cmd.emit_ld) begin
            out_value_reg <= rd_data_reg;
            out_last_reg  <= emit_last;
            out_ovf_reg   <= dropped_reg;
            k_reg         <= k_reg + AW'(1);
        end
    end

    assign sts.bi_zero   = (bi_reg == '0);
    assign sts.hsize_gt1 = (hsize_reg > CW'(1));
    assign sts.lc_in     = lc_in;
    assign sts.big_none  = !lc_gt_reg && !rc_gt;
    assign sts.out_busy  = out_valid_reg;
    assign sts.emit_last = emit_last;

    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;
    assign out_valid = out_valid_reg;

    // A pending result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_ld |-> !out_valid_reg)
        else $error("output register loaded while a result is pending");

    // The element count never passes the store capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    // Elements are dropped only once the store is full.
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        dropped_reg |-> full)
        else $error("drop flag set with room left in the store");

    // A sift step only ever descends to a child inside the heap.
    a_move_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sft_move |-> (big_idx < hsize_ext))
        else $error("sift step moved outside the heap");

endmodule

// ----- src/hse_ctrl.sv -----
// ============================================================================
// hse_ctrl
// Sequencer of the heap sort engine: load, heap build, extraction and
// emission, issuing one datapath command set per cycle.
// ============================================================================
module hse_ctrl
    import hse_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    input  hse_sts_t sts,
    output hse_cmd_t cmd
);

    hse_state_t state_reg, state_next;
    logic       ext_reg, ext_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            ext_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ext_reg   <= ext_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ext_next   = ext_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_tvalid && s_tlast) begin
                    state_next = ST_BLD_INIT;
                end
            end
            ST_BLD_INIT: begin
                ext_next   = 1'b0;
                state_next = ST_BLD_CHK;
            end
            ST_BLD_CHK: begin
                state_next = sts.bi_zero ? ST_EXT_CHK : ST_SFT_RDP;
            end
            ST_SFT_RDP:  state_next = ST_SFT_GETV;
            ST_SFT_GETV: state_next = ST_SFT_RDL;
            ST_SFT_RDL: begin
                if (sts.lc_in) begin
                    state_next = ST_SFT_RDR;
                end else begin
                    state_next = ext_reg ? ST_EXT_CHK : ST_BLD_CHK;
                end
            end
            ST_SFT_RDR: state_next = ST_SFT_CMP;
            ST_SFT_CMP: state_next = ST_SFT_DEC;
            ST_SFT_DEC: begin
                if (sts.big_none) begin
                    state_next = ext_reg ? ST_EXT_CHK : ST_BLD_CHK;
                end else begin
                    state_next = ST_SFT_RDL;
                end
            end
            ST_EXT_CHK: begin
                ext_next   = 1'b1;
                state_next = sts.hsize_gt1 ? ST_EXT_RD0 : ST_EMIT_RD;
            end
            ST_EXT_RD0: state_next = ST_EXT_RDE;
            ST_EXT_RDE: state_next = ST_EXT_WR;
            ST_EXT_WR:  state_next = ST_SFT_RDL;
            ST_EMIT_RD: begin
                if (!sts.out_busy) begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                state_next = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_BLD_INIT: cmd.bld_init = 1'b1;
            ST_BLD_CHK:  cmd.bld_dec  = !sts.bi_zero;
            ST_SFT_RDP:  cmd.rd_pos   = 1'b1;
            ST_SFT_GETV: cmd.cap_val  = 1'b1;
            ST_SFT_RDL: begin
                cmd.rd_lc  = sts.lc_in;
                cmd.wr_val = !sts.lc_in;
            end
            ST_SFT_RDR: cmd.cap_lc_rd_rc = 1'b1;
            ST_SFT_CMP: cmd.cap_rc       = 1'b1;
            ST_SFT_DEC: begin
                cmd.wr_val   = sts.big_none;
                cmd.sft_move = !sts.big_none;
            end
            ST_EXT_CHK: cmd.emit_init       = !sts.hsize_gt1;
            ST_EXT_RD0: cmd.rd_root         = 1'b1;
            ST_EXT_RDE: cmd.cap_root_rd_end = 1'b1;
            ST_EXT_WR:  cmd.ext_swap        = 1'b1;
            ST_EMIT_RD: cmd.emit_rd         = !sts.out_busy;
            ST_EMIT_LD: begin
                cmd.emit_ld  = 1'b1;
                cmd.run_done = sts.emit_last;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ----- src/heap_sort_engine.sv -----
// ============================================================================
// heap_sort_engine
// In-place heap sort of a set of signed 32-bit values, streamed in and
// streamed back out in ascending order.
// ============================================================================
//
//  Channel   Direction  Ports                               Content
//  s_*       in         s_tvalid s_tready s_tdata s_tlast   value, last
//  m_*       out        m_tvalid m_tready m_tdata m_tlast   sorted_value, final_res,
//                       m_tuser                             overflow
//
//  During loading the input is always ready. The closing transfer (tlast)
//  starts the sort; input is then held off until the final result of the run
//  is in the output register.
//  Build and extraction go through a single-read, single-write element memory:
//  each heap level visited by a sift steps through the states ST_SFT_RDL,
//  ST_SFT_RDR, ST_SFT_CMP and ST_SFT_DEC. Emission reads and loads each
//  result in the states ST_EMIT_RD and ST_EMIT_LD, waiting in ST_EMIT_RD
//  while the output register still holds a result.
//  Reset (aresetn low, synchronous) clears the element count, the drop flag,
//  the output valid and the controller; the memory is not cleared.
//  A stall on the output side freezes the emission sequence in place.
//
module heap_sort_engine
    import hse_pkg::*;
#(
    parameter int CAPACITY = HSE_CAPACITY
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Input stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [HSE_DW-1:0] s_tdata,   // [31:0] value
    input  logic              s_tlast,   // last element of the set
    // Result stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [HSE_DW-1:0] m_tdata,   // [31:0] sorted_value
    output logic              m_tlast,   // final result of the run
    output logic [0:0]        m_tuser    // [0] overflow
);

    hse_cmd_t cmd;
    hse_sts_t sts;
    logic     out_ovf;

    // The controller sequences load, heap build, extraction and emission.
    hse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath owns the element memory and the output register, so a
    // finished result waits there while the next set is already loading.
    hse_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_value  (s_tdata),
        .out_value (m_tdata),
        .out_last  (m_tlast),
        .out_ovf   (out_ovf),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    assign m_tuser = out_ovf;

endmodule

// ----- test/hse_sort_checker.sv -----
// ============================================================================
// hse_sort_checker
// Watches both streams of the heap sort engine. It keeps its own sorted copy
// of the set being loaded, and on the closing transfer it queues the sorted
// results. Each result transfer is compared with the oldest queued one.
// ============================================================================
module hse_sort_checker
    import hse_pkg::*;
#(
    parameter int CAPACITY = HSE_CAPACITY
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [HSE_DW-1:0] s_tdata,   // [31:0] value
    input  logic              s_tlast,   // last element of the set
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [HSE_DW-1:0] m_tdata,   // [31:0] sorted_value
    input  logic              m_tlast,   // final result of the run
    input  logic [0:0]        m_tuser,   // [0] overflow
    output int unsigned       fail_count,
    output int unsigned       pending_count
);

    typedef struct packed {
        logic signed [HSE_DW-1:0] value;
        logic                     final_res;
        logic                     overflow;
    } sorted_word_t;

    sorted_word_t             sorted_due[$];
    logic signed [HSE_DW-1:0] run_vals [CAPACITY];
    int                       run_count   = 0;
    logic                     run_dropped = 1'b0;
    int unsigned              errors      = 0;

    // Keeps the elements of the open set in ascending order as they arrive,
    // so the closing transfer only has to copy them out.
    task automatic absorb_value(input logic signed [HSE_DW-1:0] v);
        int slot;
        if (run_count >= CAPACITY) begin
            run_dropped = 1'b1;
        end else begin
            slot = run_count;
            while (slot > 0 && run_vals[slot-1] > v) begin
                run_vals[slot] = run_vals[slot-1];
                slot--;
            end
            run_vals[slot] = v;
            run_count++;
        end
    endtask

    task automatic release_run();
        for (int k = 0; k < run_count; k++) begin
            sorted_due.push_back('{value: run_vals[k], final_res: (k == run_count - 1),
                                   overflow: run_dropped});
        end
        run_count   = 0;
        run_dropped = 1'b0;
    endtask

    task automatic check_result(input sorted_word_t got);
        sorted_word_t want;
        if (sorted_due.size() == 0) begin
            if (errors < 10)
                $display("[%0t] unexpected result: value %0d last %0b overflow %0b",
                         $realtime, got.value, got.final_res, got.overflow);
            errors++;
        end else begin
            want = sorted_due.pop_front();
            if (got !== want) begin
                if (errors < 10)
                    $display({"[%0t] result mismatch: expected value %0d last %0b ",
                              "overflow %0b, got value %0d last %0b overflow %0b"},
                             $realtime, want.value, want.final_res, want.overflow,
                             got.value, got.final_res, got.overflow);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            sorted_due.delete();
            run_count   = 0;
            run_dropped = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_value(s_tdata);
                if (s_tlast)
                    release_run();
            end
            if (m_tvalid && m_tready)
                check_result('{value: m_tdata, final_res: m_tlast, overflow: m_tuser[0]});
        end
        fail_count    <= errors;
        pending_count <= sorted_due.size();
    end

endmodule

// ----- test/tb_heap_sort_engine.sv -----
// ============================================================================
// tb_heap_sort_engine
// Streams sets of signed values into the heap sort engine with bursty input
// and a stalling output side; a checker beside the block predicts the sorted
// output, the last marker and the overflow flag of every run.
// ============================================================================
module tb_heap_sort_engine;
    import hse_pkg::*;

    localparam int CAP          = HSE_CAPACITY;
    // Least number of items carried by the random sets, the full set and the
    // overflowing set included.
    localparam int RANDOM_ITEMS = 130;
    // Quiet cycles after the last result, to catch any stray transfer.
    localparam int FLUSH_CYCLES = 64;
    // Simulation time after which the watchdog ends the run as hung.
    localparam int RUN_LIMIT    = 4_000_000;

    // Output-side stall patterns.
    typedef enum int {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_SPARSE,
        RDY_TOGGLE
    } ready_mode_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [HSE_DW-1:0] s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [HSE_DW-1:0] m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;

    int unsigned fail_count;
    int unsigned pending_count;

    ready_mode_t ready_mode = RDY_ALWAYS;
    int          ready_hold = 0;
    int          burst_left = 0;

    heap_sort_engine #(
        .CAPACITY (CAP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    hse_sort_checker #(
        .CAPACITY (CAP)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 0;
    end

    // The output side holds one stall pattern for a random stretch of cycles
    // and then picks another. Always-ready stretches take every result as soon
    // as it is offered; the sparse pattern leaves results waiting in the output
    // register.
    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_hold <= $urandom_range(10, 120);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
            RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:    m_tready <= ~m_tready;
        endcase
    end

    // Values biased toward the interesting corners of the signed range:
    // full-range random words, small values around zero, values next to
    // both extremes, and a tiny pool that makes duplicates likely.
    function automatic logic [HSE_DW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3, 4:    return $urandom_range(0, 16) - 8;
            5:       return 32'h8000_0000 + $urandom_range(0, 3);
            6:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 3) << 30;
        endcase
    endfunction

    // Presents one element and returns at the rising edge on which it was
    // transferred. The caller is always at a rising edge. The input side
    // works in bursts: when a burst runs out, valid drops for a random gap
    // (possibly none) and a new burst length is drawn, now and then a long
    // one so that there are stretches without any idling. Ready is looked
    // at on the falling edge, where it is settled for the next rising edge.
    task automatic push_value(input logic [HSE_DW-1:0] v, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    // Holds the input side off until every queued result has been
    // transferred; returns at a rising edge.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        @(posedge aclk);
    endtask

    initial begin
        int sent;
        int set_no;
        int n;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sets. The first one holds both extremes, zero, plus and
        // minus one and the alternating bit patterns, so every data bit
        // takes both values.
        push_value(32'h7FFF_FFFF, 1'b0);
        push_value(32'h8000_0000, 1'b0);
        push_value(32'h0000_0000, 1'b0);
        push_value(32'hFFFF_FFFF, 1'b0);
        push_value(32'h0000_0001, 1'b0);
        push_value(32'h5555_5555, 1'b0);
        push_value(32'hAAAA_AAAA, 1'b1);
        // A set of one element, the most negative value.
        push_value(32'h8000_0000, 1'b1);
        // Equal values mixed with a distinct one.
        push_value(32'd3, 1'b0);
        push_value(32'd3, 1'b0);
        push_value(-32'sd3, 1'b0);
        push_value(32'd3, 1'b0);
        push_value(32'd3, 1'b1);
        // Two equal copies of the largest value.
        push_value(32'h7FFF_FFFF, 1'b0);
        push_value(32'h7FFF_FFFF, 1'b1);
        // Already in descending order, a layout that is a valid heap from the start.
        push_value(32'd4, 1'b0);
        push_value(32'd3, 1'b0);
        push_value(32'd2, 1'b0);
        push_value(32'd1, 1'b1);

        // Let the directed runs come out completely before the random part.
        wait_drained();

        // Random sets, mostly short. The second set fills the store exactly;
        // the fourth runs past capacity by one to four elements, so its closing
        // transfer is itself dropped and the whole run carries overflow.
        sent   = 0;
        set_no = 0;
        while (sent < RANDOM_ITEMS || set_no <= 3) begin
            if (set_no == 1)
                n = CAP;
            else if (set_no == 3)
                n = CAP + $urandom_range(1, 4);
            else
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
                push_value(pick_value(), (k == n - 1));
            sent += n;
            set_no++;
            // Now and then start the next set only after the output has
            // drained, so a set also begins on a fully idle engine.
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (FLUSH_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        #(RUN_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule
